// ===== rtl/lcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcb_pkg - shared types and constants
// Widths, memory geometry, mode codes and controller states of the lookahead
// convolution backward unit.
// ----------------------------------------------------------------------------
package lcb_pkg;

	localparam int TAPS      = 16;
	localparam int FEATURES  = 256;

	localparam int FEAT_W    = 8;
	localparam int TAP_W     = 4;
	localparam int SMP_W     = 16;
	localparam int PROD_W    = 2 * SMP_W;
	localparam int IG_W      = 40;
	localparam int ACC_W     = 48;
	localparam int LANE_W    = ACC_W + 1;

	localparam int FEAT_AW   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int TAP_AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int GRP       = 4;
	localparam int NGRP      = (TAPS + GRP - 1) / GRP;

	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 96;
	localparam int OUT_USER_W = 1;

	typedef enum logic [1:0] {
		MODE_LOAD_W  = 2'd0,
		MODE_SAMPLE  = 2'd1,
		MODE_READ_G  = 2'd2,
		MODE_CLEAR_G = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_SUM,
		ST_DONE
	} state_t;

	localparam logic KIND_INPUT_GRAD  = 1'b0;
	localparam logic KIND_WEIGHT_GRAD = 1'b1;

endpackage

// ===== rtl/lookahead_conv_backprop_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookahead_conv_backprop_unit - lookahead row convolution, backward pass
// Per-feature filter taps, gradient history and weight-gradient accumulators
// live in three row-wide synchronous memories, one row per feature.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                         | tuser
//  s_*     | in  | feature, tap, first_step, grad_sample,     | mode
//          |     | input_sample, weight_value, zero fill      |
//  m_*     | out | input_grad, weight_grad, saturated, fill   | value_kind
//
//  Load weight and clear gradients complete on accept; the controller stays
//  idle. A sample step: memory read, multiply, accumulate and write back,
//  final sum, output load; a gradient read has only read and output load.
//  The output register frees the controller while a result waits; a low
//  m_tready stalls the next output load. Reset clears the controller, the
//  output valid and the per-row accumulator valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module lookahead_conv_backprop_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// feature[7:0], tap[11:8], first_step[12], grad_sample[28:13],
	// input_sample[44:29], weight_value[60:45], zero[63:61]
	input  logic [lcb_pkg::IN_DATA_W-1:0]   s_tdata,
	// mode[1:0]
	input  logic [lcb_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// input_grad[39:0], weight_grad[87:40], saturated[88], zero[95:89]
	output logic [lcb_pkg::OUT_DATA_W-1:0]  m_tdata,
	// value_kind[0]
	output logic [lcb_pkg::OUT_USER_W-1:0]  m_tuser
);
	import lcb_pkg::*;

	// input fields
	mode_t                  in_mode;
	logic [FEAT_W-1:0]      in_feature;
	logic [TAP_W-1:0]       in_tap;
	logic                   in_first;
	logic [SMP_W-1:0]       in_grad, in_x, in_w;
	logic                   s_fire, feat_ok, tap_ok;

	assign in_mode    = mode_t'(s_tuser);
	assign in_feature = s_tdata[7:0];
	assign in_tap     = s_tdata[11:8];
	assign in_first   = s_tdata[12];
	assign in_grad    = s_tdata[28:13];
	assign in_x       = s_tdata[44:29];
	assign in_w       = s_tdata[60:45];
	assign s_fire     = s_tvalid && s_tready;
	assign feat_ok    = {1'b0, in_feature} < (FEAT_W + 1)'(FEATURES);
	assign tap_ok     = {1'b0, in_tap} < (TAP_W + 1)'(TAPS);

	// memories
	logic [TAPS*SMP_W-1:0]  w_mem   [FEATURES];
	logic [TAPS*SMP_W-1:0]  h_mem   [FEATURES];
	logic [TAPS*LANE_W-1:0] a_mem   [FEATURES];
	logic [TAPS*SMP_W-1:0]  w_rd_q, h_rd_q;
	logic [TAPS*LANE_W-1:0] a_rd_q;
	logic [FEATURES-1:0]    row_valid_q;

	// item registers
	mode_t                  mode_q;
	logic [FEAT_AW-1:0]     feat_q;
	logic [TAP_AW-1:0]      tap_q;
	logic                   first_q;
	logic signed [SMP_W-1:0] g_q, x_q;

	// pipeline
	logic signed [PROD_W-1:0] pig_s2 [TAPS];
	logic signed [PROD_W-1:0] pdw_s2 [TAPS];
	logic [TAPS*LANE_W-1:0]   acc_s2;
	logic signed [IG_W-1:0]   part_s3 [NGRP];

	// result and output registers
	logic                     res_kind_q, res_sat_q;
	logic signed [IG_W-1:0]   res_ig_q;
	logic signed [ACC_W-1:0]  res_wg_q;
	logic                     m_valid_q, m_kind_q, m_sat_q;
	logic [IG_W-1:0]          m_ig_q;
	logic [ACC_W-1:0]         m_wg_q;

	// controller
	state_t state_q, state_d;
	logic   go, h_we, a_we, out_load, out_free;

	assign out_free = !m_valid_q || m_tready;
	assign go = s_fire && feat_ok && (in_mode == MODE_SAMPLE ||
		(in_mode == MODE_READ_G && tap_ok));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (go) state_d = ST_READ;
			ST_READ: state_d = (mode_q == MODE_SAMPLE) ? ST_MAC : ST_DONE;
			ST_MAC:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		s_tready = 1'b0;
		h_we     = 1'b0;
		a_we     = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_READ: h_we = (mode_q == MODE_SAMPLE);
			ST_MAC:  a_we = 1'b1;
			ST_SUM:  ;
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_q  <= in_mode;
			feat_q  <= in_feature[FEAT_AW-1:0];
			tap_q   <= in_tap[TAP_AW-1:0];
			first_q <= in_first;
			g_q     <= in_grad;
			x_q     <= in_x;
		end
	end

	// weight memory: lane write on load, row read on accept
	always_ff @(posedge clk) begin
		if (s_fire && in_mode == MODE_LOAD_W && feat_ok && tap_ok)
			w_mem[in_feature[FEAT_AW-1:0]][in_tap[TAP_AW-1:0]*SMP_W +: SMP_W] <= in_w;
		w_rd_q <= w_mem[in_feature[FEAT_AW-1:0]];
	end

	// tap inputs for the sample step
	logic signed [SMP_W-1:0] gk [TAPS];
	logic [TAPS*SMP_W-1:0]   h_new;
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			if (k == 0)       gk[k] = g_q;
			else if (first_q) gk[k] = '0;
			else              gk[k] = h_rd_q[(k-1)*SMP_W +: SMP_W];
		end
		for (int k = 0; k < TAPS; k++) h_new[k*SMP_W +: SMP_W] = gk[k];
	end

	// history memory: read on accept, shifted row written back
	always_ff @(posedge clk) begin
		if (h_we) h_mem[feat_q] <= h_new;
		h_rd_q <= h_mem[in_feature[FEAT_AW-1:0]];
	end

	// multiply every tap
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			for (int k = 0; k < TAPS; k++) begin
				pig_s2[k] <= gk[k] * $signed(w_rd_q[k*SMP_W +: SMP_W]);
				pdw_s2[k] <= gk[k] * x_q;
			end
			acc_s2 <= row_valid_q[feat_q] ? a_rd_q : '0;
		end
	end

	// accumulate with saturation
	logic [TAPS*LANE_W-1:0]  a_new;
	logic signed [ACC_W:0]   acc_sum [TAPS];
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			acc_sum[k] = $signed(acc_s2[k*LANE_W +: ACC_W]) + (ACC_W + 1)'(pdw_s2[k]);
			if (acc_sum[k][ACC_W] != acc_sum[k][ACC_W-1]) begin
				a_new[k*LANE_W +: ACC_W] = acc_sum[k][ACC_W] ?
					{1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
				a_new[k*LANE_W + ACC_W]  = 1'b1;
			end else begin
				a_new[k*LANE_W +: ACC_W] = acc_sum[k][ACC_W-1:0];
				a_new[k*LANE_W + ACC_W]  = acc_s2[k*LANE_W + ACC_W];
			end
		end
	end

	// accumulator memory and row valid bits
	always_ff @(posedge clk) begin
		if (a_we) a_mem[feat_q] <= a_new;
		a_rd_q <= a_mem[in_feature[FEAT_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (s_fire && in_mode == MODE_CLEAR_G) begin
			row_valid_q <= '0;
		end else if (a_we) begin
			row_valid_q[feat_q] <= 1'b1;
		end
	end

	// input gradient: group partial sums
	always_ff @(posedge clk) begin
		if (state_q == ST_MAC) begin
			for (int gi = 0; gi < NGRP; gi++) begin
				logic signed [IG_W-1:0] ps;
				ps = '0;
				for (int j = 0; j < GRP; j++)
					if (gi * GRP + j < TAPS)
						ps = ps + IG_W'(pig_s2[gi * GRP + j]);
				part_s3[gi] <= ps;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && mode_q == MODE_READ_G) begin
			res_kind_q <= KIND_WEIGHT_GRAD;
			res_ig_q   <= '0;
			res_wg_q   <= row_valid_q[feat_q] ? $signed(a_rd_q[tap_q*LANE_W +: ACC_W]) : '0;
			res_sat_q  <= row_valid_q[feat_q] && a_rd_q[tap_q*LANE_W + ACC_W];
		end else if (state_q == ST_SUM) begin
			logic signed [IG_W-1:0] tot;
			tot = '0;
			for (int gi = 0; gi < NGRP; gi++) tot = tot + part_s3[gi];
			res_kind_q <= KIND_INPUT_GRAD;
			res_ig_q   <= tot;
			res_wg_q   <= '0;
			res_sat_q  <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       m_valid_q <= 1'b0;
		else if (out_load) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_kind_q <= res_kind_q;
			m_ig_q   <= res_ig_q;
			m_wg_q   <= res_wg_q;
			m_sat_q  <= res_sat_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_sat_q, m_wg_q, m_ig_q};
	assign m_tuser  = m_kind_q;

endmodule
